// ===== rtl/tst_pkg.sv =====
// tst_pkg: shared types and constants of the timer slot table.
// Used by every module in rtl/; depends on nothing.
package tst_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int INTERVAL_W    = 29;
  localparam int DUE_W         = 64;

  // delay_ms / 10 as multiply by reciprocal, exact for all 32-bit inputs
  localparam logic [31:0] DIV_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV_SHIFT = 35;
  localparam logic [INTERVAL_W-1:0] MIN_TICKS = INTERVAL_W'(1);

  // command codes
  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // status codes
  localparam logic [1:0] STS_OK          = 2'd0;
  localparam logic [1:0] STS_NO_FREE     = 2'd1;
  localparam logic [1:0] STS_BAD_ID      = 2'd2;
  localparam logic [1:0] STS_NOTHING_DUE = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] delay_ms;
    logic        periodic;
    logic [4:0]  slot_id;
    logic [63:0] now_ticks;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] result_id;
    logic       fired;
    logic       last;
    logic [4:0] active_count;
  } out_word_t;

  typedef struct packed {
    logic                  periodic;
    logic [INTERVAL_W-1:0] interval;
    logic [DUE_W-1:0]      due;
  } slot_ent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET,
    ST_SINGLE,
    ST_TICK_RD,
    ST_TICK_EV,
    ST_TICK_END
  } fsm_t;

endpackage

// ===== rtl/tst_slot_mem.sv =====
// tst_slot_mem: per-slot storage (repeat flag, interval, due time).
// One write port, one read port, registered read data. Uses tst_pkg.
module tst_slot_mem #(
  parameter int NUM_SLOTS = tst_pkg::NUM_SLOTS_DEF,
  parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  tst_pkg::slot_ent_t  wdata,
  input  logic                re,
  input  logic [IDX_W-1:0]    raddr,
  output tst_pkg::slot_ent_t  rdata
);
  import tst_pkg::*;

  slot_ent_t mem [NUM_SLOTS];
  slot_ent_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

  // controller never reads the entry it is writing back in the same cycle
  a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
    we && re |-> waddr != raddr)
    else $error("slot memory read and write hit the same entry");

endmodule

// ===== rtl/tst_div10.sv =====
// tst_div10: delay_ms to tick interval (divide by 10, at least 1 tick).
// Reciprocal multiply, product registered. Uses tst_pkg.
module tst_div10 (
  input  logic                            clk,
  input  logic                            en,
  input  logic [31:0]                     delay_ms,
  output logic [tst_pkg::INTERVAL_W-1:0]  ticks
);
  import tst_pkg::*;

  logic [63:0]           prod_r;
  logic [INTERVAL_W-1:0] quot;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(delay_ms) * 64'(DIV_RECIP);
    end
  end

  assign quot  = prod_r[DIV_SHIFT +: INTERVAL_W];
  assign ticks = (quot < MIN_TICKS) ? MIN_TICKS : quot;

endmodule

// ===== rtl/timer_slot_table_top.sv =====
// timer_slot_table_top: table of software timer slots with set/clear/tick.
// Instantiates tst_slot_mem and tst_div10; uses tst_pkg.
//
// Usage:
//   in_valid/in_stall/in_data carry one command word. in_stall is high
//   whenever a command is still being worked on; one command at a time.
//   out_valid/out_stall/out_data carry result words from an output register.
//   Set, clear and unknown commands give one word, loaded into the output
//   register from ST_SET or ST_SINGLE once that register is free.
//   Tick walks the slot memory once, one entry per cycle while not held by
//   output stall, and gives one word per due slot in index order, or one
//   nothing-due word if none is due; the final word of a command has last set.
//   The walk is paced by the single read port of the slot memory.
//   If out_stall is held, the walk pauses at a due slot while a word is
//   pending and resumes when the output register drains; nothing is dropped.
//   Reset frees every slot (used bits are flip-flops cleared at once); the
//   slot memory itself is not cleared, entries are written by set before use.
//   No clearing pass is needed after reset.
module timer_slot_table_top #(
  parameter int NUM_SLOTS = tst_pkg::NUM_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tst_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tst_pkg::out_word_t out_data
);
  import tst_pkg::*;

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_RAW = $clog2(NUM_SLOTS + 1);
  localparam int CNT_W  = (CNT_RAW > 5) ? CNT_RAW : 5;

  fsm_t                 state_r, state_nxt;
  in_word_t             in_r;
  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;

  // pending tick result: held back until we know whether it is the last one
  logic                 pend_valid_r, pend_valid_nxt;
  logic [4:0]           pend_id_r, pend_id_nxt;
  logic [4:0]           pend_cnt_r, pend_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_r, out_nxt;

  // slot memory port
  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  slot_ent_t            mem_wdata, mem_rdata;

  logic                  div_en;
  logic [INTERVAL_W-1:0] ticks;

  logic                  accept;
  logic                  out_free;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [6:0]            free_id7, ev_id7, clr_m1;
  logic [IDX_W-1:0]      clr_idx;
  logic                  clr_ok;
  logic                  ev_due;
  logic [CNT_W-1:0]      ev_cnt;

  tst_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tst_div10 u_div (
    .clk      (clk),
    .en       (div_en),
    .delay_ms (in_data.delay_ms),
    .ticks    (ticks)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign free_id7 = 7'(free_idx) + 7'd1;
  assign ev_id7   = 7'(idx_r) + 7'd1;
  assign clr_m1   = 7'(in_r.slot_id) - 7'd1;
  assign clr_idx  = clr_m1[IDX_W-1:0];
  assign clr_ok   = (in_r.slot_id != 5'd0) && (32'(in_r.slot_id) <= 32'(NUM_SLOTS));

  // slot under scan is due when used and now has reached its due time
  assign ev_due = used_r[idx_r] && !(in_r.now_ticks < mem_rdata.due);
  assign ev_cnt = mem_rdata.periodic ? count_r : count_r - CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    pend_cnt_nxt   = pend_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = idx_r;
    div_en         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          div_en = 1'b1;
          case (in_data.command)
            CMD_SET:  state_nxt = ST_SET;
            CMD_TICK: state_nxt = ST_TICK_RD;
            default:  state_nxt = ST_SINGLE;
          endcase
        end
      end

      ST_SET: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (free_found) begin
            used_nxt[free_idx] = 1'b1;
            count_nxt          = count_r + CNT_W'(1);
            mem_we             = 1'b1;
            mem_waddr          = free_idx;
            mem_wdata.periodic = in_r.periodic;
            mem_wdata.interval = ticks;
            mem_wdata.due      = in_r.now_ticks + DUE_W'(ticks);
            out_nxt = '{status: STS_OK, result_id: free_id7[4:0], fired: 1'b0,
                        last: 1'b1, active_count: count_nxt[4:0]};
          end else begin
            out_nxt = '{status: STS_NO_FREE, result_id: 5'd0, fired: 1'b0,
                        last: 1'b1, active_count: count_r[4:0]};
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_SINGLE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (in_r.command == CMD_CLEAR && clr_ok) begin
            used_nxt[clr_idx] = 1'b0;
            count_nxt         = count_r - CNT_W'(used_r[clr_idx]);
            out_nxt = '{status: STS_OK, result_id: in_r.slot_id, fired: 1'b0,
                        last: 1'b1, active_count: count_nxt[4:0]};
          end else if (in_r.command == CMD_CLEAR) begin
            out_nxt = '{status: STS_BAD_ID, result_id: 5'd0, fired: 1'b0,
                        last: 1'b1, active_count: count_r[4:0]};
          end else begin
            out_nxt = '{status: STS_NOTHING_DUE, result_id: 5'd0, fired: 1'b0,
                        last: 1'b1, active_count: count_r[4:0]};
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_TICK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        idx_nxt   = '0;
        state_nxt = ST_TICK_EV;
      end

      ST_TICK_EV: begin
        // a due slot replaces the pending word, which must move out first
        if (!ev_due || !pend_valid_r || out_free) begin
          if (ev_due) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{status: STS_OK, result_id: pend_id_r, fired: 1'b1,
                          last: 1'b0, active_count: pend_cnt_r};
            end
            if (mem_rdata.periodic) begin
              mem_we        = 1'b1;
              mem_waddr     = idx_r;
              mem_wdata.due = in_r.now_ticks + DUE_W'(mem_rdata.interval);
            end else begin
              used_nxt[idx_r] = 1'b0;
            end
            count_nxt      = ev_cnt;
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = ev_id7[4:0];
            pend_cnt_nxt   = ev_cnt[4:0];
          end
          if (idx_r == IDX_W'(NUM_SLOTS - 1)) begin
            state_nxt = ST_TICK_END;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_r + IDX_W'(1);
            idx_nxt   = idx_r + IDX_W'(1);
          end
        end
      end

      ST_TICK_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_nxt = '{status: STS_OK, result_id: pend_id_r, fired: 1'b1,
                        last: 1'b1, active_count: pend_cnt_r};
          end else begin
            out_nxt = '{status: STS_NOTHING_DUE, result_id: 5'd0, fired: 1'b0,
                        last: 1'b1, active_count: count_r[4:0]};
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_r       <= '0;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    idx_r      <= idx_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    out_r      <= out_nxt;
  end

  // running count tracks the used bits
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(used_r)))
    else $error("active count out of step with used bits");

  // a held-back tick word only exists during the scan
  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> state_r == ST_TICK_EV || state_r == ST_TICK_END)
    else $error("pending tick word outside a tick scan");

  // scan index stays inside the table
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TICK_EV |-> int'(idx_r) < NUM_SLOTS)
    else $error("scan index beyond last slot");

endmodule
